[rtl/lrapq_pkg.sv]
// Shared constants, types and state codes of the lazy range-add tree.
package lrapq_pkg;

    localparam int MAX_POSITIONS = 1024;
    localparam int POS_W         = 11;
    localparam int NODE_AW       = 12;
    localparam int NODE_DEPTH    = 4096;
    localparam int DATA_W        = 32;
    localparam int STK_DEPTH     = 11;
    localparam int STK_AW        = 4;

    typedef logic [NODE_AW-1:0] t_node;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [DATA_W-1:0]  t_word;

    // one access to both node stores (shared address)
    typedef struct packed {
        logic  we;
        t_node addr;
        t_word wsum;
        t_word wtag;
    } t_mem_cmd;

    // saved frame of the tree walk
    typedef struct packed {
        t_node      node;
        t_pos       l;
        t_pos       r;
        logic [1:0] ph;
    } t_frame;

    typedef enum logic [19:0] {
        S_CLR     = 20'h00001,
        S_IDLE    = 20'h00002,
        S_A_ENTRY = 20'h00004,
        S_A_COV   = 20'h00008,
        S_A_DESC  = 20'h00010,
        S_A_SUM0  = 20'h00020,
        S_A_SUM1  = 20'h00040,
        S_A_SUM2  = 20'h00080,
        S_A_RET   = 20'h00100,
        S_P0      = 20'h00200,
        S_P1      = 20'h00400,
        S_P2      = 20'h00800,
        S_P3      = 20'h01000,
        S_P4      = 20'h02000,
        S_P5      = 20'h04000,
        S_Q_LOOP  = 20'h08000,
        S_Q_STEP  = 20'h10000,
        S_Q_RD    = 20'h20000,
        S_Q_FIN   = 20'h40000,
        S_RESULT  = 20'h80000
    } t_state;

    localparam logic [1:0] PH_LEFT  = 2'd0;
    localparam logic [1:0] PH_RIGHT = 2'd1;
    localparam logic [1:0] PH_SUM   = 2'd2;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

endpackage

[rtl/lrapq_store.sv]
// Node sum and pending-tag stores: synchronous RAMs, one shared address.
module lrapq_store import lrapq_pkg::*; (
    input  logic     i_clk,
    input  t_mem_cmd i_cmd,
    output t_word    o_q_sum,
    output t_word    o_q_tag
);

    t_word r_sum_mem [NODE_DEPTH];
    t_word r_tag_mem [NODE_DEPTH];

    // write both stores, registered read of both
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_sum_mem[i_cmd.addr] <= i_cmd.wsum;
            r_tag_mem[i_cmd.addr] <= i_cmd.wtag;
        end
        o_q_sum <= r_sum_mem[i_cmd.addr];
        o_q_tag <= r_tag_mem[i_cmd.addr];
    end

endmodule

[rtl/lazy_range_add_point_query_tree_unit.sv]
// Top level: lazy segment tree with range add and point query.
//
// Input channel (i_in_valid / o_in_stall): one request item, a range add
// (delta over positions range_lo..range_hi) or a point query (point_index).
// Output channel (o_out_valid / i_out_stall): one item per point query,
// point_value and index_error; a range add gives no item.
// Configuration: i_cfg_we writes n_used (positions covered) at once.
// Reset (synchronous, i_rst_n low) sets n_used to 1024 and then sweeps both
// node stores to zero, one entry a cycle, with o_in_stall high.
// One item is worked at a time; o_in_stall is high while it runs. Every node
// update is a read-modify-write of the one-port store pair, whose read is
// registered. A covered node goes through entry, cover and return; a partly
// covered node through entry, tag push (cut short when it holds no tag),
// descend, parent sum and return. A point query pushes tags down one tree
// level at a time and then reads the leaf sum.
// A bad query goes from idle straight to the result state. A result waits
// in the output register while i_out_stall is high; the next item is already
// accepted, and a second result waits inside until the first one is taken.
module lazy_range_add_point_query_tree_unit import lrapq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [POS_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [POS_W-1:0]   i_range_lo,
    input  logic [POS_W-1:0]   i_range_hi,
    input  logic signed [31:0] i_delta,
    input  logic [POS_W-1:0]   i_point_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_point_value,
    output logic               o_index_error
);

    t_state           r_state;
    t_pos             r_cfg_n;
    t_node            r_clr;
    t_node            r_node;
    t_pos             r_l;
    t_pos             r_r;
    logic [1:0]       r_ph;
    logic             r_mode;
    t_pos             r_lo;
    t_pos             r_hi;
    t_word            r_d;
    t_word            r_prod;
    t_word            r_tag;
    t_word            r_nsum;
    t_word            r_ls;
    t_word            r_lt;
    t_word            r_rs;
    t_word            r_rt;
    t_word            r_res_val;
    logic             r_res_err;
    logic             r_o_valid;
    t_word            r_o_value;
    logic             r_o_err;
    logic [STK_AW-1:0] r_sp;
    t_frame           r_stk [STK_DEPTH];

    t_mem_cmd w_cmd;
    t_word    w_q_sum;
    t_word    w_q_tag;
    t_pos     w_n;
    t_pos     w_mid;
    t_pos     w_span;
    t_node    w_lc;
    t_node    w_rc;
    logic     w_accept;
    t_frame   w_top;

    lrapq_store u_store (
        .i_clk   (i_clk),
        .i_cmd   (w_cmd),
        .o_q_sum (w_q_sum),
        .o_q_tag (w_q_tag)
    );

    // effective position count, clamped to 1..MAX_POSITIONS
    always_comb begin
        if (r_cfg_n == '0) begin
            w_n = POS_W'(1);
        end else if (r_cfg_n > POS_W'(MAX_POSITIONS)) begin
            w_n = POS_W'(MAX_POSITIONS);
        end else begin
            w_n = r_cfg_n;
        end
    end

    assign w_mid    = POS_W'(({1'b0, r_l} + {1'b0, r_r}) >> 1);
    assign w_span   = r_r - r_l + POS_W'(1);
    assign w_lc     = {r_node[NODE_AW-2:0], 1'b0};
    assign w_rc     = {r_node[NODE_AW-2:0], 1'b1};
    assign w_top    = r_stk[r_sp - STK_AW'(1)];
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept = i_in_valid && !o_in_stall;

    assign o_out_valid   = r_o_valid;
    assign o_point_value = r_o_value;
    assign o_index_error = r_o_err;

    // store access per state
    always_comb begin
        w_cmd.we   = 1'b0;
        w_cmd.addr = r_node;
        w_cmd.wsum = '0;
        w_cmd.wtag = '0;
        case (r_state)
            S_CLR: begin
                w_cmd.we   = 1'b1;
                w_cmd.addr = r_clr;
            end
            S_A_COV: begin
                w_cmd.we   = 1'b1;
                w_cmd.wsum = w_q_sum + r_prod;
                w_cmd.wtag = w_q_tag + r_d;
            end
            S_P1:     w_cmd.addr = w_lc;
            S_P2:     w_cmd.addr = w_rc;
            S_P3: begin
                w_cmd.we   = 1'b1;
                w_cmd.addr = w_lc;
                w_cmd.wsum = r_ls + r_prod;
                w_cmd.wtag = r_lt + r_tag;
            end
            S_P4: begin
                w_cmd.we   = 1'b1;
                w_cmd.addr = w_rc;
                w_cmd.wsum = r_rs + r_prod;
                w_cmd.wtag = r_rt + r_tag;
            end
            S_P5: begin
                w_cmd.we   = 1'b1;
                w_cmd.wsum = r_nsum;
            end
            S_A_SUM0: w_cmd.addr = w_lc;
            S_A_SUM1: w_cmd.addr = w_rc;
            S_A_SUM2: begin
                w_cmd.we   = 1'b1;
                w_cmd.wsum = r_ls + w_q_sum;
            end
            default:  w_cmd.addr = r_node;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
            r_cfg_n   <= POS_W'(MAX_POSITIONS);
        end else begin
            if (i_cfg_we) begin
                r_cfg_n <= i_cfg_wdata;
            end
            // output register: load a waiting result, or drop a taken one
            if (r_state == S_RESULT && (!r_o_valid || !i_out_stall)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + NODE_AW'(1);
                    if (r_clr == NODE_AW'(NODE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_hi   <= i_range_hi;
                        r_d    <= t_word'(i_delta);
                        r_node <= NODE_AW'(1);
                        r_l    <= POS_W'(1);
                        r_r    <= w_n;
                        r_sp   <= '0;
                        r_mode <= i_req_type;
                        if (i_req_type == REQ_ADD) begin
                            r_lo <= i_range_lo;
                            if (i_range_lo != '0 && i_range_hi <= w_n &&
                                i_range_lo <= i_range_hi) begin
                                r_state <= S_A_ENTRY;
                            end
                        end else begin
                            r_lo <= i_point_index;
                            if (i_point_index == '0 || i_point_index > w_n) begin
                                r_res_val <= '0;
                                r_res_err <= 1'b1;
                                r_state   <= S_RESULT;
                            end else begin
                                r_state <= S_Q_LOOP;
                            end
                        end
                    end
                end
                // range add walk
                S_A_ENTRY: begin
                    if (r_lo <= r_l && r_hi >= r_r) begin
                        r_prod  <= r_d * t_word'(w_span);
                        r_state <= S_A_COV;
                    end else begin
                        r_ph    <= PH_LEFT;
                        r_state <= S_P0;
                    end
                end
                S_A_COV:  r_state <= S_A_RET;
                S_A_RET: begin
                    if (r_sp == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_node  <= w_top.node;
                        r_l     <= w_top.l;
                        r_r     <= w_top.r;
                        r_ph    <= w_top.ph;
                        r_sp    <= r_sp - STK_AW'(1);
                        r_state <= S_A_DESC;
                    end
                end
                S_A_DESC: begin
                    case (r_ph)
                        PH_LEFT: begin
                            if (r_lo <= w_mid) begin
                                r_stk[r_sp] <= '{node: r_node, l: r_l, r: r_r,
                                                 ph: PH_RIGHT};
                                r_sp    <= r_sp + STK_AW'(1);
                                r_node  <= w_lc;
                                r_r     <= w_mid;
                                r_state <= S_A_ENTRY;
                            end else begin
                                r_ph <= PH_RIGHT;
                            end
                        end
                        PH_RIGHT: begin
                            if (r_hi > w_mid) begin
                                r_stk[r_sp] <= '{node: r_node, l: r_l, r: r_r,
                                                 ph: PH_SUM};
                                r_sp    <= r_sp + STK_AW'(1);
                                r_node  <= w_rc;
                                r_l     <= w_mid + POS_W'(1);
                                r_state <= S_A_ENTRY;
                            end else begin
                                r_ph <= PH_SUM;
                            end
                        end
                        default: r_state <= S_A_SUM0;
                    endcase
                end
                S_A_SUM0: r_state <= S_A_SUM1;
                S_A_SUM1: begin
                    r_ls    <= w_q_sum;
                    r_state <= S_A_SUM2;
                end
                S_A_SUM2: r_state <= S_A_RET;
                // push pending tag to both children
                S_P0:     r_state <= S_P1;
                S_P1: begin
                    r_tag  <= w_q_tag;
                    r_nsum <= w_q_sum;
                    if (w_q_tag == '0) begin
                        r_state <= (r_mode == REQ_QUERY) ? S_Q_STEP : S_A_DESC;
                    end else begin
                        r_state <= S_P2;
                    end
                end
                S_P2: begin
                    r_ls    <= w_q_sum;
                    r_lt    <= w_q_tag;
                    r_prod  <= r_tag * t_word'(w_span - (w_span >> 1));
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_rs    <= w_q_sum;
                    r_rt    <= w_q_tag;
                    r_prod  <= r_tag * t_word'(w_span >> 1);
                    r_state <= S_P4;
                end
                S_P4:     r_state <= S_P5;
                S_P5: begin
                    r_state <= (r_mode == REQ_QUERY) ? S_Q_STEP : S_A_DESC;
                end
                // point query walk
                S_Q_LOOP: r_state <= (r_l < r_r) ? S_P0 : S_Q_RD;
                S_Q_STEP: begin
                    if (r_lo <= w_mid) begin
                        r_node <= w_lc;
                        r_r    <= w_mid;
                    end else begin
                        r_node <= w_rc;
                        r_l    <= w_mid + POS_W'(1);
                    end
                    r_state <= S_Q_LOOP;
                end
                S_Q_RD:   r_state <= S_Q_FIN;
                S_Q_FIN: begin
                    r_res_val <= w_q_sum;
                    r_res_err <= 1'b0;
                    r_state   <= S_RESULT;
                end
                S_RESULT: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_value <= r_res_val;
                        r_o_err   <= r_res_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
